/* hdl/nnds_pkg.sv */
// ----------------------------------------------------------------------------
// nnds_pkg
// Shared types, codes and reset values of the nearest-neighbor downscaler.
// ----------------------------------------------------------------------------
package nnds_pkg;

    // Field and register widths.
    localparam int COMP_W      = 8;
    localparam int CFG_DIM_W   = 13;
    localparam int CFG_CU_W    = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int CFG_INDEX_W = 3;

    // Default for the largest frame dimension handled.
    localparam int MAX_DIM_DEFAULT = 4096;

    // Register values after reset.
    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_WIDTH    = 13'd640;
    localparam logic [CFG_DIM_W-1:0] RST_SOURCE_HEIGHT   = 13'd480;
    localparam logic [CFG_DIM_W-1:0] RST_TARGET_WIDTH    = 13'd640;
    localparam logic [CFG_DIM_W-1:0] RST_TARGET_HEIGHT   = 13'd480;
    localparam logic [CFG_CU_W-1:0]  RST_COMPONENTS_USED = 3'd4;

    // Register indexes of the configuration port.
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SOURCE_WIDTH    = 3'd0,
        CFG_SOURCE_HEIGHT   = 3'd1,
        CFG_TARGET_WIDTH    = 3'd2,
        CFG_TARGET_HEIGHT   = 3'd3,
        CFG_COMPONENTS_USED = 3'd4
    } t_cfg_index;

    // Result status codes.
    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_BAD_RES = 1'b1;

    // Configuration register set.
    typedef struct packed {
        logic [CFG_DIM_W-1:0] source_width;
        logic [CFG_DIM_W-1:0] source_height;
        logic [CFG_DIM_W-1:0] target_width;
        logic [CFG_DIM_W-1:0] target_height;
        logic [CFG_CU_W-1:0]  components_used;
    } t_cfg;

    // One source pixel.
    typedef struct packed {
        logic [COMP_W-1:0] comp0;
        logic [COMP_W-1:0] comp1;
        logic [COMP_W-1:0] comp2;
        logic [COMP_W-1:0] comp3;
    } t_pixel_in;

    // One result item.
    typedef struct packed {
        logic [COMP_W-1:0] out_comp0;
        logic [COMP_W-1:0] out_comp1;
        logic [COMP_W-1:0] out_comp2;
        logic [COMP_W-1:0] out_comp3;
        logic              row_end;
        logic              frame_end;
        logic              status;
    } t_pixel_out;

endpackage

/* hdl/nnds_stream_if.sv */
// ----------------------------------------------------------------------------
// nnds_stream_if
// Valid/ready stream channel carrying one item of type T per handshake.
// ----------------------------------------------------------------------------
interface nnds_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hdl/nnds_core.sv */
// ----------------------------------------------------------------------------
// nnds_core
// Pixel selection: source and output position counters, rational step
// accumulators, and the result item for each kept pixel, or a status item.
// ----------------------------------------------------------------------------
module nnds_core #(
    parameter int MAX_DIM = nnds_pkg::MAX_DIM_DEFAULT
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  nnds_pkg::t_cfg       i_cfg,
    input  logic                 i_accept,
    input  nnds_pkg::t_pixel_in  i_pixel,
    output logic                 o_result_valid,
    output nnds_pkg::t_pixel_out o_result
);

    localparam int     DW     = $clog2(MAX_DIM + 1);
    localparam longint AccMax = longint'(MAX_DIM) * (longint'(MAX_DIM) + 64'sd1);
    localparam int     AW     = $clog2(AccMax + 64'sd1);
    localparam int     CW     = (DW > nnds_pkg::CFG_DIM_W) ? DW : nnds_pkg::CFG_DIM_W;

    // Clamp a register value to the supported dimension range.
    function automatic logic [DW-1:0] clamp_dim(
        input logic [nnds_pkg::CFG_DIM_W-1:0] v,
        input logic                           at_least_one
    );
        logic [CW-1:0] ext;
        ext = CW'(v);
        if (at_least_one && (ext == '0)) begin
            return DW'(1);
        end
        if (ext > CW'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end
        return DW'(ext);
    endfunction

    logic [DW-1:0] r_src_col, n_src_col;
    logic [DW-1:0] r_src_row, n_src_row;
    logic [DW-1:0] r_out_col, n_out_col;
    logic [DW-1:0] r_out_row, n_out_row;
    logic [AW-1:0] r_col_tacc, n_col_tacc;
    logic [AW-1:0] r_col_sacc, n_col_sacc;
    logic [AW-1:0] r_row_tacc, n_row_tacc;
    logic [AW-1:0] r_row_sacc, n_row_sacc;
    logic          r_row_kept, n_row_kept;
    logic          r_err, n_err;

    logic [DW-1:0]                sw, sh, tw, th;
    logic [nnds_pkg::CFG_CU_W-1:0] cu;
    logic                         first_pix;
    logic                         invalid;
    logic                         row_kept;
    logic                         col_hit;
    logic [DW:0]                  src_col_inc, src_row_inc, out_col_inc, out_row_inc;
    logic                         row_end;

    // Effective dimensions and component count.
    always_comb begin
        sw = clamp_dim(i_cfg.source_width, 1'b1);
        sh = clamp_dim(i_cfg.source_height, 1'b1);
        tw = clamp_dim(i_cfg.target_width, 1'b0);
        th = clamp_dim(i_cfg.target_height, 1'b0);
        if (i_cfg.components_used == '0) begin
            cu = 3'd1;
        end else if (i_cfg.components_used > 3'd4) begin
            cu = 3'd4;
        end else begin
            cu = i_cfg.components_used;
        end
    end

    // Selection tests and the result item.
    always_comb begin
        first_pix   = (r_src_col == '0) && (r_src_row == '0);
        invalid     = (tw > sw) || (th > sh);
        src_col_inc = {1'b0, r_src_col} + 1'b1;
        src_row_inc = {1'b0, r_src_row} + 1'b1;
        out_col_inc = {1'b0, r_out_col} + 1'b1;
        out_row_inc = {1'b0, r_out_row} + 1'b1;

        // The row decision is taken on the first pixel of each source row.
        if (r_src_col == '0) begin
            row_kept = (r_out_row < th) && (r_row_tacc < (r_row_sacc + AW'(th)));
        end else begin
            row_kept = r_row_kept;
        end
        col_hit = (r_out_col < tw) && (r_col_tacc < (r_col_sacc + AW'(tw)));
        row_end = (out_col_inc == {1'b0, tw});

        o_result_valid = 1'b0;
        o_result       = '0;
        if (invalid) begin
            if (first_pix && !r_err) begin
                o_result_valid     = 1'b1;
                o_result.frame_end = 1'b1;
                o_result.status    = nnds_pkg::STATUS_BAD_RES;
            end
        end else if (!r_err && row_kept && col_hit) begin
            o_result_valid     = 1'b1;
            o_result.out_comp0 = i_pixel.comp0;
            o_result.out_comp1 = (cu > 3'd1) ? i_pixel.comp1 : '0;
            o_result.out_comp2 = (cu > 3'd2) ? i_pixel.comp2 : '0;
            o_result.out_comp3 = (cu > 3'd3) ? i_pixel.comp3 : '0;
            o_result.row_end   = row_end;
            o_result.frame_end = row_end && (out_row_inc == {1'b0, th});
            o_result.status    = nnds_pkg::STATUS_OK;
        end
    end

    // Position and accumulator update for an accepted pixel.
    always_comb begin
        n_src_col  = r_src_col;
        n_src_row  = r_src_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_col_tacc = r_col_tacc;
        n_col_sacc = r_col_sacc;
        n_row_tacc = r_row_tacc;
        n_row_sacc = r_row_sacc;
        n_row_kept = r_row_kept;
        n_err      = r_err;
        if (i_accept) begin
            n_row_kept = row_kept;
            if (invalid) begin
                if (first_pix) begin
                    n_err = 1'b1;
                end
            end else if (!r_err && row_kept && col_hit) begin
                n_out_col  = DW'(out_col_inc);
                n_col_tacc = r_col_tacc + AW'(sw);
            end
            n_col_sacc = r_col_sacc + AW'(tw);

            if (src_col_inc >= {1'b0, sw}) begin
                // End of the source row.
                if (row_kept) begin
                    n_out_row  = DW'(out_row_inc);
                    n_row_tacc = r_row_tacc + AW'(sh);
                end
                n_row_sacc = r_row_sacc + AW'(th);
                n_src_col  = '0;
                n_out_col  = '0;
                n_col_tacc = '0;
                n_col_sacc = '0;
                if (src_row_inc >= {1'b0, sh}) begin
                    // End of the source frame.
                    n_src_row  = '0;
                    n_out_row  = '0;
                    n_row_tacc = '0;
                    n_row_sacc = '0;
                    n_row_kept = 1'b0;
                    n_err      = 1'b0;
                end else begin
                    n_src_row = DW'(src_row_inc);
                end
            end else begin
                n_src_col = DW'(src_col_inc);
            end
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_col  <= '0;
            r_src_row  <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_col_tacc <= '0;
            r_col_sacc <= '0;
            r_row_tacc <= '0;
            r_row_sacc <= '0;
            r_row_kept <= 1'b0;
            r_err      <= 1'b0;
        end else begin
            r_src_col  <= n_src_col;
            r_src_row  <= n_src_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_col_tacc <= n_col_tacc;
            r_col_sacc <= n_col_sacc;
            r_row_tacc <= n_row_tacc;
            r_row_sacc <= n_row_sacc;
            r_row_kept <= n_row_kept;
            r_err      <= n_err;
        end
    end

endmodule

/* hdl/nearest_neighbor_downscale_unit.sv */
// ----------------------------------------------------------------------------
// nearest_neighbor_downscale_unit
// Nearest-neighbor downscaler over a raster-order pixel stream.
// ----------------------------------------------------------------------------
// The unit takes one source pixel per clock while ready is high: the column
// and row selection is one add and compare on the accumulators, done as the
// pixel is accepted, and a kept pixel is registered in the output register,
// or in the skid register while the output register is full. The two-entry
// output stage lets input keep flowing while a result waits; ready drops only
// when both entries hold results. Pixels that are not kept produce no item. A
// target larger than the source yields one status item on the first pixel of
// the frame; a zero target yields nothing.
module nearest_neighbor_downscale_unit #(
    parameter int MAX_DIM = nnds_pkg::MAX_DIM_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [nnds_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [nnds_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    nnds_stream_if.sink                        i_pix,
    nnds_stream_if.source                      o_pix
);

    nnds_pkg::t_cfg       r_cfg;
    logic                 accept;
    logic                 res_valid;
    nnds_pkg::t_pixel_out res;

    logic                 r_out_valid, n_out_valid;
    logic                 r_skid_valid, n_skid_valid;
    nnds_pkg::t_pixel_out r_out_data, n_out_data;
    nnds_pkg::t_pixel_out r_skid_data, n_skid_data;
    logic                 out_fire;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_width    <= nnds_pkg::RST_SOURCE_WIDTH;
            r_cfg.source_height   <= nnds_pkg::RST_SOURCE_HEIGHT;
            r_cfg.target_width    <= nnds_pkg::RST_TARGET_WIDTH;
            r_cfg.target_height   <= nnds_pkg::RST_TARGET_HEIGHT;
            r_cfg.components_used <= nnds_pkg::RST_COMPONENTS_USED;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                nnds_pkg::CFG_SOURCE_WIDTH: begin
                    r_cfg.source_width <= i_cfg_data;
                end
                nnds_pkg::CFG_SOURCE_HEIGHT: begin
                    r_cfg.source_height <= i_cfg_data;
                end
                nnds_pkg::CFG_TARGET_WIDTH: begin
                    r_cfg.target_width <= i_cfg_data;
                end
                nnds_pkg::CFG_TARGET_HEIGHT: begin
                    r_cfg.target_height <= i_cfg_data;
                end
                nnds_pkg::CFG_COMPONENTS_USED: begin
                    r_cfg.components_used <= i_cfg_data[nnds_pkg::CFG_CU_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Input handshake: blocked only while both output entries are full.
    assign i_pix.ready = !r_skid_valid;
    assign accept      = i_pix.valid && !r_skid_valid;

    nnds_core #(
        .MAX_DIM (MAX_DIM)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_accept       (accept),
        .i_pixel        (i_pix.data),
        .o_result_valid (res_valid),
        .o_result       (res)
    );

    // Output register and skid register.
    always_comb begin
        out_fire     = r_out_valid && o_pix.ready;
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            if (out_fire) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (accept && res_valid) begin
            if (!r_out_valid || out_fire) begin
                n_out_valid = 1'b1;
                n_out_data  = res;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = res;
            end
        end else if (out_fire) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_pix.valid = r_out_valid;
    assign o_pix.data  = r_out_data;

endmodule
